>>> hdl/varint_sign_magnitude_decoder_top_assert.svh
// Assertion macros for the varint decoder RTL.
`ifndef VARINT_SIGN_MAGNITUDE_DECODER_TOP_ASSERT_SVH
`define VARINT_SIGN_MAGNITUDE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VSMD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define VSMD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/vsmd_pkg.sv
// Constants for the sign-magnitude varint decoder.
`timescale 1ns / 1ps
package vsmd_pkg;
	localparam int unsigned CONT_BIT   = 7;
	localparam int unsigned SIGN_BIT   = 6;
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned TOP_BITS   = 6;
	localparam int unsigned POS_W      = 7;
	localparam int unsigned OUT_W      = 64;
	localparam logic [POS_W-1:0] POS_MAX  = 7'd127;
	localparam logic [POS_W-1:0] POS_STEP = 7'd7;
endpackage

>>> hdl/varint_sign_magnitude_decoder_top.sv
// Top level of the sign-magnitude varint decoder.
`timescale 1ns / 1ps
// Usage:
//   Byte channel: data_byte and is_signed, taken when byte_valid is high and
//   byte_stall is low. Bit 7 set marks a continuation word; bits 6..0 go into
//   the accumulator 7 bits at a time, least significant group first. A word
//   with bit 7 clear ends the value: bit 6 is the sign, bits 5..0 the top bits.
//   Result channel: value, sign_ignored and overflow, taken when value_valid is
//   high and value_stall is low. One result per final word, none otherwise.
//   Path: a final word is held in the input register, then in the result register.
//   Throughput: one word per cycle while byte_stall is low; the input register
//   feeds one pass of shift, OR and conditional negate into accumulator or result.
//   Stall: continuation words keep flowing while a result waits. A final word
//   waits in the input register while the result register is full and
//   stalled, and byte_stall is raised until it can move.
//   Reset: arst_n clears the accumulator, bit position, overflow flag and all
//   valid flags; no result is pending after reset.
//   value is VALUE_WIDTH bits wide internally, zero-extended to 64 bits.
module varint_sign_magnitude_decoder_top #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	output logic                      byte_stall,
	input  logic [7:0]                data_byte,
	input  logic                      is_signed,
	output logic                      value_valid,
	input  logic                      value_stall,
	output logic [vsmd_pkg::OUT_W-1:0] value,
	output logic                      sign_ignored,
	output logic                      overflow
);
	import vsmd_pkg::*;

	`include "varint_sign_magnitude_decoder_top_assert.svh"

	localparam int unsigned WIDE_W = VALUE_WIDTH + GROUP_BITS;
	localparam logic [POS_W-1:0] WIDTH_POS = POS_W'(VALUE_WIDTH);

	// Input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   signed_s1;

	// Decode state
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [POS_W-1:0]       pos_q;
	logic                   ovf_q;

	// Result register
	logic                   value_valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   sign_ignored_q;
	logic                   overflow_q;

	logic                   final_s1;
	logic                   adv_s1;
	logic                   byte_take;
	logic [GROUP_BITS-1:0]  grp;
	logic [WIDE_W-1:0]      placed_wide;
	logic [VALUE_WIDTH-1:0] placed_lo;
	logic                   placed_ovf;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   sign;
	logic [POS_W:0]         pos_sum;
	logic [POS_W-1:0]       pos_next;

	assign final_s1  = !byte_s1[CONT_BIT];
	// A final word needs room in the result register; continuation words never wait.
	assign adv_s1    = valid_s1 && (!final_s1 || !value_valid_q || !value_stall);
	assign byte_stall = valid_s1 && !adv_s1;
	assign byte_take = byte_valid && !byte_stall;

	always_comb begin
		if (final_s1) begin
			grp = {1'b0, byte_s1[TOP_BITS-1:0]};
		end else begin
			grp = byte_s1[GROUP_BITS-1:0];
		end
		placed_wide = WIDE_W'(grp) << pos_q;
		if (pos_q >= WIDTH_POS) begin
			placed_lo  = '0;
			placed_ovf = |grp;
		end else begin
			placed_lo  = placed_wide[VALUE_WIDTH-1:0];
			placed_ovf = |placed_wide[WIDE_W-1:VALUE_WIDTH];
		end
		mag     = acc_q | placed_lo;
		sign    = byte_s1[SIGN_BIT];
		pos_sum = {1'b0, pos_q} + {1'b0, POS_STEP};
		// Saturate the position instead of wrapping
		if (pos_sum > {1'b0, POS_MAX}) begin
			pos_next = POS_MAX;
		end else begin
			pos_next = pos_sum[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			byte_s1   <= data_byte;
			signed_s1 <= is_signed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv_s1) begin
			if (final_s1) begin
				acc_q <= '0;
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				acc_q <= mag;
				pos_q <= pos_next;
				ovf_q <= ovf_q | placed_ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid_q <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			value_valid_q <= 1'b1;
		end else if (!value_stall) begin
			value_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && final_s1) begin
			// Negate modulo 2^VALUE_WIDTH in signed mode when the sign bit is set
			if (signed_s1 && sign) begin
				value_q <= '0 - mag;
			end else begin
				value_q <= mag;
			end
			sign_ignored_q <= !signed_s1 && sign;
			overflow_q     <= ovf_q | placed_ovf;
		end
	end

	assign value_valid  = value_valid_q;
	assign value        = OUT_W'(value_q);
	assign sign_ignored = sign_ignored_q;
	assign overflow     = overflow_q;

	`VSMD_ASSERT_NOW(a_stall_only_on_full_result, byte_stall,
		valid_s1 && final_s1 && value_valid_q && value_stall)
	`VSMD_ASSERT_NEXT(a_final_clears_state, adv_s1 && final_s1,
		pos_q == '0 && acc_q == '0 && !ovf_q)
	`VSMD_ASSERT_NEXT(a_cont_advances_pos,
		adv_s1 && !final_s1 && pos_q <= (POS_MAX - POS_STEP),
		pos_q == $past(pos_q) + POS_STEP)
endmodule

>>> verif/tb.sv
// Self-checking testbench for the sign-magnitude varint decoder top level.
`timescale 1ns / 1ps
module tb;
	import vsmd_pkg::*;

	typedef struct {
		logic [7:0]  code;
		logic        signed_mode;
		int unsigned gap;
	} enc_word_t;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic             sign_ignored;
		logic             overflow;
	} decoded_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             byte_valid = 1'b0;
	logic             byte_stall;
	logic [7:0]       data_byte = 8'h00;
	logic             is_signed = 1'b0;
	logic             value_valid;
	logic             value_stall = 1'b0;
	logic [OUT_W-1:0] value;
	logic             sign_ignored;
	logic             overflow;

	enc_word_t   words_to_send[$];
	decoded_t    pending_values[$];
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned words_queued = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;
	bit          failed = 1'b0;

	// Decoder state as the block should hold it.
	logic [OUT_W-1:0] acc = '0;
	logic [POS_W-1:0] bit_pos = '0;
	logic             dropped = 1'b0;

	varint_sign_magnitude_decoder_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.is_signed   (is_signed),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.sign_ignored(sign_ignored),
		.overflow    (overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// OR a group in at the current position; flag nonzero bits that fall off the top.
	task automatic place_group(input logic [6:0] grp, input int unsigned nbits);
		int unsigned      p;
		logic [OUT_W-1:0] g;
		p = bit_pos;
		g = OUT_W'(grp);
		if (g == '0)
			return;
		if (p >= OUT_W) begin
			dropped = 1'b1;
			return;
		end
		acc |= g << p;
		if (p + nbits > OUT_W && (g >> (OUT_W - p)) != '0)
			dropped = 1'b1;
	endtask

	task automatic decode_word(input logic [7:0] code, input logic signed_mode);
		decoded_t r;
		logic     sign;
		if (code[CONT_BIT]) begin
			place_group(code[GROUP_BITS-1:0], GROUP_BITS);
			if (int'(bit_pos) + GROUP_BITS <= int'(POS_MAX))
				bit_pos = bit_pos + POS_STEP;
			else
				bit_pos = POS_MAX;
			return;
		end
		place_group({1'b0, code[TOP_BITS-1:0]}, TOP_BITS);
		sign = code[SIGN_BIT];
		r.value = (signed_mode && sign) ? -acc : acc;
		r.sign_ignored = !signed_mode && sign;
		r.overflow = dropped;
		pending_values.push_back(r);
		acc = '0;
		bit_pos = '0;
		dropped = 1'b0;
	endtask

	task automatic send_word(input logic [7:0] code, input logic signed_mode);
		enc_word_t w;
		w.code = code;
		w.signed_mode = signed_mode;
		w.gap = tx_burst ? 0 : $urandom_range(0, 11);
		words_to_send.push_back(w);
		words_queued++;
	endtask

	// Encode a magnitude over n_cont continuation words and one last word.
	task automatic send_value(input logic [OUT_W-1:0] mag, input int unsigned n_cont,
			input logic sign, input logic signed_mode);
		logic [OUT_W-1:0] rest;
		rest = mag;
		for (int unsigned i = 0; i < n_cont; i++) begin
			send_word({1'b1, rest[6:0]}, signed_mode);
			rest = rest >> GROUP_BITS;
		end
		send_word({1'b0, sign, rest[5:0]}, signed_mode);
	endtask

	function automatic logic [6:0] pick_group();
		case ($urandom_range(0, 9))
			0: begin
				return 7'h00;
			end
			1: begin
				return 7'h7f;
			end
			default: begin
				return 7'($urandom_range(0, 127));
			end
		endcase
	endfunction

	// Driver: present a word, hold it while stalled, advance on acceptance.
	always @(posedge clk) begin
		enc_word_t w;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				decode_word(data_byte, is_signed);
				gap_left = (words_to_send.size() > 0) ? words_to_send[0].gap : 0;
			end
			if (!byte_valid || !byte_stall) begin
				if (gap_left > 0) begin
					byte_valid <= 1'b0;
					gap_left--;
				end else if (words_to_send.size() > 0) begin
					w = words_to_send.pop_front();
					data_byte <= w.code;
					is_signed <= w.signed_mode;
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result and draw the stall before the next one.
	always @(posedge clk) begin
		decoded_t e;
		if (arst_n) begin
			if (value_valid && !value_stall) begin
				if (pending_values.size() == 0) begin
					$error("result with none expected: value %h sign_ignored %0b overflow %0b",
						value, sign_ignored, overflow);
					failed = 1'b1;
				end else begin
					e = pending_values.pop_front();
					if (value !== e.value) begin
						$error("value: expected %h, got %h", e.value, value);
						failed = 1'b1;
					end
					if (sign_ignored !== e.sign_ignored) begin
						$error("sign_ignored: expected %0b, got %0b", e.sign_ignored,
							sign_ignored);
						failed = 1'b1;
					end
					if (overflow !== e.overflow) begin
						$error("overflow: expected %0b, got %0b", e.overflow, overflow);
						failed = 1'b1;
					end
				end
				stall_left = rx_burst ? 0 : $urandom_range(0, 11);
				if ($urandom_range(0, 29) == 0)
					rx_burst = !rx_burst;
			end
			if (stall_left > 0) begin
				value_stall <= 1'b1;
				stall_left--;
			end else begin
				value_stall <= 1'b0;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("varint_sign_magnitude_decoder_top regression: fail");
		$finish;
	end

	initial begin
		int unsigned n_cont;
		int unsigned r;
		logic        signed_mode;
		logic        mixed_mode;

		// Single-word values at the field extremes, and 0x7f over two words.
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'h3f, 1'b1);
		send_word(8'h40, 1'b1);
		send_word(8'h40, 1'b0);
		send_word(8'h7f, 1'b1);
		send_word(8'h7f, 1'b0);
		send_value(64'h7f, 1, 1'b0, 1'b0);
		// Largest magnitude below bit 63, both signs.
		send_value(64'h7fff_ffff_ffff_ffff, 9, 1'b0, 1'b1);
		send_value(64'h7fff_ffff_ffff_ffff, 9, 1'b1, 1'b1);
		// Most negative magnitude: negation wraps without a flag.
		send_value(64'h8000_0000_0000_0000, 9, 1'b1, 1'b1);
		send_value(64'hffff_ffff_ffff_ffff, 9, 1'b0, 1'b0);
		send_value(64'hffff_ffff_ffff_ffff, 9, 1'b1, 1'b1);
		send_value(64'hffff_ffff_ffff_ffff, 9, 1'b1, 1'b0);
		// Top bits of the last word partly dropped.
		for (int i = 0; i < 9; i++)
			send_word(8'h80, 1'b0);
		send_word(8'h3f, 1'b0);
		// Continuation group straddling bit 63.
		for (int i = 0; i < 9; i++)
			send_word(8'h80, 1'b1);
		send_word(8'hff, 1'b1);
		send_word(8'h00, 1'b1);
		// Long run of zero groups past saturation: no flag.
		for (int i = 0; i < 25; i++)
			send_word(8'h80, 1'b0);
		send_word(8'h00, 1'b0);
		// Late nonzero groups after the position saturates.
		for (int i = 0; i < 20; i++)
			send_word(8'h80, 1'b1);
		send_word(8'h81, 1'b1);
		send_word(8'h40, 1'b1);
		for (int i = 0; i < 19; i++)
			send_word(8'h80, 1'b0);
		send_word(8'h01, 1'b0);
		// is_signed changing on continuation words only matters on the last one.
		send_word(8'hff, 1'b0);
		send_word(8'hab, 1'b1);
		send_word(8'h45, 1'b1);
		send_word(8'hd5, 1'b1);
		send_word(8'h6a, 1'b0);

		while (words_queued < 1850) begin
			if ($urandom_range(0, 24) == 0)
				tx_burst = !tx_burst;
			r = $urandom_range(0, 19);
			if (r < 14)
				n_cont = $urandom_range(0, 9);
			else if (r < 18)
				n_cont = $urandom_range(8, 10);
			else
				n_cont = $urandom_range(11, 22);
			signed_mode = 1'($urandom_range(0, 1));
			mixed_mode = ($urandom_range(0, 9) == 0);
			for (int unsigned i = 0; i < n_cont; i++)
				send_word({1'b1, pick_group()},
					mixed_mode ? 1'($urandom_range(0, 1)) : signed_mode);
			send_word({1'b0, pick_group()}, signed_mode);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || byte_valid)
			@(posedge clk);
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (!failed)
			$display("varint_sign_magnitude_decoder_top regression: pass");
		else
			$display("varint_sign_magnitude_decoder_top regression: fail");
		$finish;
	end
endmodule
